>>> rtl/lprf_pkg.sv
// Package for the length-prefixed record FIFO.
// Holds field widths, default sizes, header and serial constants and the item and status codes.
// Depends on nothing; used by length_prefixed_record_fifo_top.
package lprf_pkg;

    localparam int RING_BYTES_DEF = 8192;
    localparam int MAX_MSG_DEF    = 64;

    localparam int KIND_W   = 3;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 14;
    localparam int SERIAL_W = 27;

    localparam int HDR_BYTES = 6;
    localparam logic [SERIAL_W-1:0] SERIAL_WRAP = SERIAL_W'(100000000);

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_READ  = 3'd2,
        KIND_PEEK  = 3'd3,
        KIND_CLEAR = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_TOO_SMALL = 2'd3
    } t_status;

endpackage

>>> rtl/length_prefixed_record_fifo_top.sv
// Length-prefixed record FIFO: a byte ring of variable-length records with 6-byte headers.
// One synchronous byte memory plus a small sequencer that reads, writes and streams records.
// Depends on lprf_pkg.
//
//   channel | direction | handshake                | fields
//   --------+-----------+--------------------------+-------------------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_kind, i_length, i_data
//   out     | output    | o_out_valid / i_out_stall| o_status, o_data_out, o_record_length,
//           |           |                          | o_last, o_stored_count
//
// Each accepted word is latched and handled by a sequencer around a single-port byte memory
// with registered read data. A write data word, a clear or a rejected word goes through the
// decode and response states to the output. A good write start first writes the six header
// bytes through the one write port, one per cycle. A read or peek fetches the two length
// bytes, then each payload byte, which is fetched only after the previous one has landed in
// the output register, which must be free when the fetched byte arrives.
// Reset is synchronous and active low; it clears pointers, counters and the sequencer. The
// memory is not cleared, because no unwritten byte can reach the output.
// A stall on the output holds the output register; the input is stalled whenever the
// sequencer is busy, but a new word is taken while a finished result still waits.
module length_prefixed_record_fifo_top #(
    parameter int RING_BYTES = lprf_pkg::RING_BYTES_DEF,
    parameter int MAX_MSG    = lprf_pkg::MAX_MSG_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lprf_pkg::KIND_W-1:0]   i_kind,
    input  logic [lprf_pkg::LEN_W-1:0]    i_length,
    input  logic [lprf_pkg::BYTE_W-1:0]   i_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lprf_pkg::STATUS_W-1:0] o_status,
    output logic [lprf_pkg::BYTE_W-1:0]   o_data_out,
    output logic [lprf_pkg::LEN_W-1:0]    o_record_length,
    output logic                          o_last,
    output logic [lprf_pkg::COUNT_W-1:0]  o_stored_count
);
    import lprf_pkg::*;

    // Pointer width, and the width of a payload byte count (0..MAX_MSG).
    localparam int PW = $clog2(RING_BYTES);
    localparam int NW = $clog2(MAX_MSG + 1);
    // Step width for pointer advances: at most MAX_MSG + 4, below 128.
    localparam int KW = 7;
    localparam logic [PW:0]      RB_W   = (PW+1)'(RING_BYTES);
    localparam logic [LEN_W-1:0] MAX_L  = LEN_W'(MAX_MSG);
    localparam logic [NW-1:0]    MAX_N  = NW'(MAX_MSG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HDR,
        S_H0,
        S_H1,
        S_RD_ISSUE,
        S_RD_DATA,
        S_RESP
    } t_state;

    // Advance a ring pointer by a small step, wrapping at the ring size.
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [KW-1:0] k);
        logic [PW:0] s;
        s = {1'b0, p} + (PW+1)'(k);
        if (s >= RB_W) begin
            s = s - RB_W;
        end
        return s[PW-1:0];
    endfunction

    t_state                r_state;
    logic [KIND_W-1:0]     r_kind;
    logic [LEN_W-1:0]      r_len;
    logic [BYTE_W-1:0]     r_data;

    // Ring state. The read pointer sits on the byte just before the head record.
    logic [PW-1:0]         r_rp;
    logic [PW-1:0]         r_wp;
    logic [PW-1:0]         r_sp;
    logic [NW-1:0]         r_rem;
    logic                  r_open;
    logic [SERIAL_W-1:0]   r_serial;
    logic [COUNT_W-1:0]    r_count;

    // Sequencer working registers.
    logic [PW-1:0]         r_addr;
    logic [2:0]            r_hdr_idx;
    logic [SERIAL_W-1:0]   r_hdr_serial;
    logic [BYTE_W-1:0]     r_hi;
    logic [LEN_W-1:0]      r_hlen;
    logic [NW-1:0]         r_left;
    logic [STATUS_W-1:0]   r_resp_status;
    logic [LEN_W-1:0]      r_resp_len;

    // Output register.
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [BYTE_W-1:0]     r_out_data;
    logic [LEN_W-1:0]      r_out_len;
    logic                  r_out_last;
    logic [COUNT_W-1:0]    r_out_count;

    // Byte memory with registered read data.
    logic [BYTE_W-1:0]     mem [RING_BYTES];
    logic [BYTE_W-1:0]     r_mem_q;
    logic                  mem_we;
    logic [PW-1:0]         mem_wa;
    logic [BYTE_W-1:0]     mem_wd;
    logic                  mem_re;
    logic [PW-1:0]         mem_ra;

    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    logic [PW-1:0]         rp_next;
    logic                  ring_empty;
    logic [PW:0]           free_sum;
    logic [PW:0]           free_bytes;
    logic                  start_bad;
    logic [SERIAL_W-1:0]   serial_inc;
    logic [BYTE_W-1:0]     hdr_byte;
    logic [LEN_W-1:0]      head_len;
    logic [NW-1:0]         head_n;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    // The output register is free at the next edge if it is empty or being taken now.
    assign out_free   = !r_out_valid || !i_out_stall;
    // The output register takes a new word from a streamed byte or a single response.
    assign out_load   = (r_state == S_RD_DATA) || (r_state == S_RESP && out_free);

    assign rp_next    = adv(r_rp, KW'(1));
    assign ring_empty = (rp_next == r_wp);

    always_comb begin
        // Free space: (rp - wp - 1) mod ring size, one compare and subtract.
        free_sum   = {1'b0, r_rp} + RB_W - {1'b0, r_wp} - (PW+1)'(1);
        free_bytes = (free_sum >= RB_W) ? (free_sum - RB_W) : free_sum;
        start_bad  = (r_len == '0) || (r_len > MAX_L) ||
                     (({1'b0, r_len} + (LEN_W+1)'(HDR_BYTES)) > (LEN_W+1)'(free_bytes));
        serial_inc = (r_serial + SERIAL_W'(1) >= SERIAL_WRAP) ? '0
                                                              : (r_serial + SERIAL_W'(1));
        head_len   = {r_hi, r_mem_q};
        head_n     = (head_len > LEN_W'(MAX_N)) ? MAX_N : head_len[NW-1:0];
    end

    // Header: big-endian length, then big-endian serial in four bytes.
    always_comb begin
        case (r_hdr_idx)
            3'd0:    hdr_byte = r_len[15:8];
            3'd1:    hdr_byte = r_len[7:0];
            3'd2:    hdr_byte = BYTE_W'(r_hdr_serial[SERIAL_W-1:24]);
            3'd3:    hdr_byte = r_hdr_serial[23:16];
            3'd4:    hdr_byte = r_hdr_serial[15:8];
            default: hdr_byte = r_hdr_serial[7:0];
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = hdr_byte;
        mem_re = 1'b0;
        mem_ra = r_addr;
        unique case (r_state)
            S_DECODE: begin
                if (r_kind == KIND_DATA && r_open) begin
                    mem_we = 1'b1;
                    mem_wa = r_sp;
                    mem_wd = r_data;
                end else if ((r_kind == KIND_READ || r_kind == KIND_PEEK) && !ring_empty) begin
                    mem_re = 1'b1;
                    mem_ra = rp_next;
                end
            end
            S_HDR: begin
                mem_we = 1'b1;
            end
            S_H0: begin
                mem_re = 1'b1;
                mem_ra = adv(r_addr, KW'(1));
            end
            S_RD_ISSUE: begin
                mem_re = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= PW'(1);
            r_sp        <= '0;
            r_rem       <= '0;
            r_open      <= 1'b0;
            r_serial    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind  <= i_kind;
                        r_len   <= i_length;
                        r_data  <= i_data;
                        r_state <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_resp_status <= ST_OK;
                    r_resp_len    <= '0;
                    r_state       <= S_RESP;
                    case (r_kind)
                        KIND_START: begin
                            // Any open write is abandoned, good start or not.
                            r_open <= 1'b0;
                            r_rem  <= '0;
                            if (start_bad) begin
                                r_resp_status <= ST_REJECT;
                            end else begin
                                r_addr       <= r_wp;
                                r_hdr_idx    <= '0;
                                r_hdr_serial <= serial_inc;
                                r_state      <= S_HDR;
                            end
                        end
                        KIND_DATA: begin
                            if (!r_open) begin
                                r_resp_status <= ST_REJECT;
                            end else begin
                                r_sp  <= adv(r_sp, KW'(1));
                                r_rem <= r_rem - NW'(1);
                                if (r_rem == NW'(1)) begin
                                    // Final byte commits the record.
                                    r_wp     <= adv(r_sp, KW'(1));
                                    r_serial <= serial_inc;
                                    r_count  <= r_count + COUNT_W'(1);
                                    r_open   <= 1'b0;
                                end
                            end
                        end
                        KIND_READ, KIND_PEEK: begin
                            if (ring_empty) begin
                                r_resp_status <= ST_EMPTY;
                            end else begin
                                r_addr  <= rp_next;
                                r_state <= S_H0;
                            end
                        end
                        KIND_CLEAR: begin
                            r_rp    <= '0;
                            r_wp    <= PW'(1);
                            r_open  <= 1'b0;
                            r_rem   <= '0;
                            r_count <= '0;
                        end
                        default: begin
                        end
                    endcase
                end

                S_HDR: begin
                    r_addr    <= adv(r_addr, KW'(1));
                    r_hdr_idx <= r_hdr_idx + 3'd1;
                    if (r_hdr_idx == 3'(HDR_BYTES - 1)) begin
                        r_sp          <= adv(r_addr, KW'(1));
                        r_rem         <= r_len[NW-1:0];
                        r_open        <= 1'b1;
                        r_resp_status <= ST_OK;
                        r_resp_len    <= '0;
                        r_state       <= S_RESP;
                    end
                end

                S_H0: begin
                    r_hi    <= r_mem_q;
                    r_addr  <= adv(r_addr, KW'(1));
                    r_state <= S_H1;
                end

                S_H1: begin
                    // r_addr holds the low length byte; the payload starts five bytes on.
                    r_hlen <= head_len;
                    if (r_len < head_len) begin
                        r_resp_status <= ST_TOO_SMALL;
                        r_resp_len    <= head_len;
                        r_state       <= S_RESP;
                    end else begin
                        if (r_kind == KIND_READ) begin
                            r_rp <= adv(r_addr, KW'(head_n) + KW'(4));
                            if (r_count != '0) begin
                                r_count <= r_count - COUNT_W'(1);
                            end
                        end
                        r_addr <= adv(r_addr, KW'(5));
                        r_left <= head_n;
                        if (head_n == '0) begin
                            r_resp_status <= ST_OK;
                            r_resp_len    <= head_len;
                            r_state       <= S_RESP;
                        end else begin
                            r_state <= S_RD_ISSUE;
                        end
                    end
                end

                S_RD_ISSUE: begin
                    if (out_free) begin
                        r_state <= S_RD_DATA;
                    end
                end

                S_RD_DATA: begin
                    // The output register was emptied when this byte was fetched.
                    r_out_status <= ST_OK;
                    r_out_data   <= r_mem_q;
                    r_out_len    <= r_hlen;
                    r_out_last   <= (r_left == NW'(1));
                    r_out_count  <= r_count;
                    r_addr       <= adv(r_addr, KW'(1));
                    r_left       <= r_left - NW'(1);
                    r_state      <= (r_left == NW'(1)) ? S_IDLE : S_RD_ISSUE;
                end

                S_RESP: begin
                    if (out_free) begin
                        r_out_status <= r_resp_status;
                        r_out_data   <= '0;
                        r_out_len    <= r_resp_len;
                        r_out_last   <= 1'b1;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_data_out      = r_out_data;
    assign o_record_length = r_out_len;
    assign o_last          = r_out_last;
    assign o_stored_count  = r_out_count;

    // One ring byte always stays free, so the pointers never meet.
    a_ptr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp != r_wp)
        else $error("read and write pointers coincide");

    // An open write always has payload bytes left to take.
    a_open_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_rem != '0))
        else $error("write open with no bytes remaining");

    // The record count and the pointers agree on emptiness.
    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == ring_empty)
        else $error("record count disagrees with ring pointers");

    // The single memory port never reads and writes in one cycle.
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    // A fetched payload byte always finds the output register empty.
    a_fetch_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_ISSUE && out_free) |=> !r_out_valid)
        else $error("fetched byte would overwrite a waiting result");

endmodule
